// ===== hdl/cftp_pkg.sv =====
package cftp_pkg;

    localparam logic [7:0] SYNC_FIRST = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'h66;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam int HEAD_DEPTH = 6;
    localparam int ZOOM_MIN_LENGTH = 2;
    localparam int ATTITUDE_MIN_LENGTH = 6;

    typedef enum logic [3:0] {
        PH_HUNT0,
        PH_HUNT1,
        PH_VER,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_SEQ_LO,
        PH_SEQ_HI,
        PH_CMD,
        PH_PAYLOAD,
        PH_CRC_LO,
        PH_CRC_HI
    } phase_t;

    typedef enum logic [1:0] {
        ST_ZOOM     = 2'd0,
        ST_ATTITUDE = 2'd1,
        ST_IGNORED  = 2'd2,
        ST_CRC_BAD  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_ZOOM_COMMAND     = 2'd0,
        CFG_READ_ATT_COMMAND = 2'd1,
        CFG_SET_ATT_COMMAND  = 2'd2,
        CFG_EXTERNAL_ATT     = 2'd3
    } cfg_index_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] c;
        c = crc ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    localparam logic [15:0] SYNC_CRC = crc_byte(crc_byte(16'h0000, SYNC_FIRST), SYNC_SECOND);

endpackage

// ===== hdl/crc16_framed_telemetry_parser.sv =====
// Framed telemetry parser: takes one link byte per cycle, hunts for the sync pair 0x55 0x66,
// parses version, length, sequence, command and payload, checks the CRC-16 (poly 0x1021,
// init 0) and emits one result when the last CRC byte of a frame arrives. A byte is taken
// into an input register and worked on from there by a single unrolled CRC step and the
// frame sequencer, which write a frame's result into the output register. The sustained rate
// is one byte per cycle; the input stalls only when a frame ends while the previous result
// is still held by a stalled output.
module crc16_framed_telemetry_parser
    import cftp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [7:0]         command,
    output logic [15:0]        sequence_res,
    output logic [15:0]        payload_length,
    output logic [15:0]        zoom_tenths,
    output logic signed [15:0] yaw_raw,
    output logic signed [15:0] pitch_raw,
    output logic signed [15:0] roll_raw,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_go;
    logic        out_free;

    logic [7:0]  zoom_cmd_reg;
    logic [7:0]  read_att_cmd_reg;
    logic [7:0]  set_att_cmd_reg;
    logic        external_att_reg;

    phase_t      phase_reg, phase_next;
    logic [15:0] idx_reg, idx_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] seq_reg, seq_next;
    logic [7:0]  head_reg [HEAD_DEPTH];
    logic [7:0]  head_next [HEAD_DEPTH];
    logic [7:0]  crc_lo_reg, crc_lo_next;

    logic        emit;
    logic [15:0] crc_step;
    logic [16:0] idx_inc;
    logic [15:0] rx_crc;
    status_t     res_status;
    logic [15:0] res_zoom;
    logic [15:0] res_yaw;
    logic [15:0] res_pitch;
    logic [15:0] res_roll;

    logic               out_valid_reg;
    status_t            status_reg;
    logic [7:0]         command_reg;
    logic [15:0]        sequence_reg;
    logic [15:0]        length_reg;
    logic [15:0]        zoom_reg;
    logic signed [15:0] yaw_reg;
    logic signed [15:0] pitch_reg;
    logic signed [15:0] roll_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign emit      = s1_valid_reg && (phase_reg == PH_CRC_HI);
    assign s1_go     = s1_valid_reg && (!emit || out_free);
    assign in_stall  = s1_valid_reg && !s1_go;

    assign crc_step = crc_byte(crc_reg, s1_byte_reg);
    assign idx_inc  = {1'b0, idx_reg} + 17'd1;
    assign rx_crc   = {s1_byte_reg, crc_lo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            zoom_cmd_reg     <= '0;
            read_att_cmd_reg <= '0;
            set_att_cmd_reg  <= '0;
            external_att_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_ZOOM_COMMAND:     zoom_cmd_reg     <= cfg_data;
                CFG_READ_ATT_COMMAND: read_att_cmd_reg <= cfg_data;
                CFG_SET_ATT_COMMAND:  set_att_cmd_reg  <= cfg_data;
                CFG_EXTERNAL_ATT:     external_att_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall) begin
            s1_byte_reg <= rx_byte;
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        idx_next    = idx_reg;
        len_next    = len_reg;
        crc_next    = crc_reg;
        cmd_next    = cmd_reg;
        seq_next    = seq_reg;
        crc_lo_next = crc_lo_reg;
        for (int i = 0; i < HEAD_DEPTH; i++) begin
            head_next[i] = head_reg[i];
        end
        res_status = ST_IGNORED;
        res_zoom   = '0;
        res_yaw    = '0;
        res_pitch  = '0;
        res_roll   = '0;

        case (phase_reg)
            PH_HUNT0:
            begin
                if (s1_byte_reg == SYNC_FIRST) begin
                    phase_next = PH_HUNT1;
                end
            end
            PH_HUNT1:
            begin
                if (s1_byte_reg == SYNC_SECOND) begin
                    crc_next   = SYNC_CRC;
                    idx_next   = '0;
                    len_next   = '0;
                    seq_next   = '0;
                    cmd_next   = '0;
                    for (int i = 0; i < HEAD_DEPTH; i++) begin
                        head_next[i] = '0;
                    end
                    phase_next = PH_VER;
                end
                else if (s1_byte_reg != SYNC_FIRST) begin
                    phase_next = PH_HUNT0;
                end
            end
            PH_VER:
            begin
                crc_next   = crc_step;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                crc_next   = crc_step;
                len_next   = {8'h00, s1_byte_reg};
                phase_next = PH_LEN_HI;
            end
            PH_LEN_HI:
            begin
                crc_next   = crc_step;
                len_next   = {s1_byte_reg, len_reg[7:0]};
                phase_next = PH_SEQ_LO;
            end
            PH_SEQ_LO:
            begin
                crc_next   = crc_step;
                seq_next   = {8'h00, s1_byte_reg};
                phase_next = PH_SEQ_HI;
            end
            PH_SEQ_HI:
            begin
                crc_next   = crc_step;
                seq_next   = {s1_byte_reg, seq_reg[7:0]};
                phase_next = PH_CMD;
            end
            PH_CMD:
            begin
                crc_next   = crc_step;
                cmd_next   = s1_byte_reg;
                idx_next   = '0;
                phase_next = (len_reg == 16'd0) ? PH_CRC_LO : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                crc_next = crc_step;
                for (int i = 0; i < HEAD_DEPTH; i++) begin
                    if (idx_reg == 16'(i)) begin
                        head_next[i] = s1_byte_reg;
                    end
                end
                idx_next = idx_inc[15:0];
                if (idx_inc >= {1'b0, len_reg}) begin
                    phase_next = PH_CRC_LO;
                end
            end
            PH_CRC_LO:
            begin
                crc_lo_next = s1_byte_reg;
                phase_next  = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                phase_next = PH_HUNT0;
                if (rx_crc != crc_reg) begin
                    res_status = ST_CRC_BAD;
                end
                else if (cmd_reg == zoom_cmd_reg && len_reg >= 16'(ZOOM_MIN_LENGTH)) begin
                    res_status = ST_ZOOM;
                    res_zoom   = {head_reg[1], head_reg[0]};
                end
                else if ((cmd_reg == read_att_cmd_reg || cmd_reg == set_att_cmd_reg) &&
                         len_reg >= 16'(ATTITUDE_MIN_LENGTH) && !external_att_reg) begin
                    res_status = ST_ATTITUDE;
                    res_yaw    = {head_reg[1], head_reg[0]};
                    res_pitch  = {head_reg[3], head_reg[2]};
                    res_roll   = {head_reg[5], head_reg[4]};
                end
                else begin
                    res_status = ST_IGNORED;
                end
            end
            default:
            begin
                phase_next = PH_HUNT0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_HUNT0;
            idx_reg    <= '0;
            len_reg    <= '0;
            crc_reg    <= '0;
            cmd_reg    <= '0;
            seq_reg    <= '0;
            crc_lo_reg <= '0;
            for (int i = 0; i < HEAD_DEPTH; i++) begin
                head_reg[i] <= '0;
            end
        end
        else if (s1_go) begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            len_reg    <= len_next;
            crc_reg    <= crc_next;
            cmd_reg    <= cmd_next;
            seq_reg    <= seq_next;
            crc_lo_reg <= crc_lo_next;
            for (int i = 0; i < HEAD_DEPTH; i++) begin
                head_reg[i] <= head_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && emit) begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && emit) begin
            status_reg   <= res_status;
            command_reg  <= cmd_reg;
            sequence_reg <= seq_reg;
            length_reg   <= len_reg;
            zoom_reg     <= res_zoom;
            yaw_reg      <= res_yaw;
            pitch_reg    <= res_pitch;
            roll_reg     <= res_roll;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign command        = command_reg;
    assign sequence_res   = sequence_reg;
    assign payload_length = length_reg;
    assign zoom_tenths    = zoom_reg;
    assign yaw_raw        = yaw_reg;
    assign pitch_raw      = pitch_reg;
    assign roll_raw       = roll_reg;

endmodule

// ===== hdl/cftp_checker.sv =====
module cftp_checker
    import cftp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic [15:0]        payload_length,
    input logic [15:0]        zoom_tenths,
    input logic signed [15:0] yaw_raw,
    input logic signed [15:0] pitch_raw,
    input logic signed [15:0] roll_raw
);

    // A stalled result stays in place until it is transferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(payload_length))
    else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_ATTITUDE |-> yaw_raw == 0 && pitch_raw == 0 && roll_raw == 0)
    else $error("attitude fields set on a non-attitude result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_ZOOM |-> zoom_tenths == 16'd0)
    else $error("zoom field set on a non-zoom result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_ZOOM |-> payload_length >= 16'(ZOOM_MIN_LENGTH))
    else $error("zoom report from a short frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_ATTITUDE |-> payload_length >= 16'(ATTITUDE_MIN_LENGTH))
    else $error("attitude report from a short frame");

endmodule

bind crc16_framed_telemetry_parser cftp_checker u_cftp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .payload_length (payload_length),
    .zoom_tenths    (zoom_tenths),
    .yaw_raw        (yaw_raw),
    .pitch_raw      (pitch_raw),
    .roll_raw       (roll_raw)
);

// ===== tb/frame_check_pkg.sv =====
`timescale 1ns / 100ps

package frame_check_pkg;

    import cftp_pkg::*;

    typedef struct packed {
        status_t            status;
        logic [7:0]         command;
        logic [15:0]        seq_num;
        logic [15:0]        pay_len;
        logic [15:0]        zoom;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } frame_report_t;

    class frame_scoreboard;

        logic [7:0]    zoom_code;
        logic [7:0]    read_att_code;
        logic [7:0]    set_att_code;
        logic          ext_att;

        phase_t        phase;
        logic [16:0]   pay_count;
        logic [15:0]   len_q;
        logic [15:0]   crc_q;
        logic [15:0]   seq_q;
        logic [7:0]    cmd_q;
        logic [7:0]    crc_lo_q;
        logic [7:0]    head_q [HEAD_DEPTH];

        frame_report_t expected_reports [$];
        int            errors;

        function new();
            zoom_code = '0;
            read_att_code = '0;
            set_att_code = '0;
            ext_att = 1'b0;
            phase = PH_HUNT0;
            pay_count = '0;
            len_q = '0;
            crc_q = '0;
            seq_q = '0;
            cmd_q = '0;
            crc_lo_q = '0;
            foreach (head_q[i])
            begin
                head_q[i] = '0;
            end
            errors = 0;
        endfunction

        // Bit-serial form of the XMODEM CRC, MSB first.
        static function logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
            logic feedback;
            for (int k = 7; k >= 0; k--)
            begin
                feedback = crc[15] ^ b[k];
                crc = {crc[14:0], 1'b0};
                if (feedback)
                begin
                    crc = crc ^ CRC_POLY;
                end
            end
            return crc;
        endfunction

        function void write_reg(input cfg_index_t idx, input logic [7:0] d);
            case (idx)
                CFG_ZOOM_COMMAND:     zoom_code = d;
                CFG_READ_ATT_COMMAND: read_att_code = d;
                CFG_SET_ATT_COMMAND:  set_att_code = d;
                CFG_EXTERNAL_ATT:     ext_att = d[0];
                default: ;
            endcase
        endfunction

        function void report(input string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void take_byte(input logic [7:0] b);
            frame_report_t r;
            r = '0;
            case (phase)
                PH_HUNT0:
                begin
                    if (b == SYNC_FIRST)
                    begin
                        phase = PH_HUNT1;
                    end
                end
                PH_HUNT1:
                begin
                    if (b == SYNC_SECOND)
                    begin
                        crc_q = crc_update(crc_update(16'h0000, SYNC_FIRST), SYNC_SECOND);
                        pay_count = '0;
                        len_q = '0;
                        seq_q = '0;
                        cmd_q = '0;
                        foreach (head_q[i])
                        begin
                            head_q[i] = '0;
                        end
                        phase = PH_VER;
                    end
                    else if (b != SYNC_FIRST)
                    begin
                        phase = PH_HUNT0;
                    end
                end
                PH_VER:
                begin
                    crc_q = crc_update(crc_q, b);
                    phase = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    crc_q = crc_update(crc_q, b);
                    len_q = {8'h00, b};
                    phase = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    crc_q = crc_update(crc_q, b);
                    len_q[15:8] = b;
                    phase = PH_SEQ_LO;
                end
                PH_SEQ_LO:
                begin
                    crc_q = crc_update(crc_q, b);
                    seq_q = {8'h00, b};
                    phase = PH_SEQ_HI;
                end
                PH_SEQ_HI:
                begin
                    crc_q = crc_update(crc_q, b);
                    seq_q[15:8] = b;
                    phase = PH_CMD;
                end
                PH_CMD:
                begin
                    crc_q = crc_update(crc_q, b);
                    cmd_q = b;
                    pay_count = '0;
                    phase = (len_q == 16'h0000) ? PH_CRC_LO : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    crc_q = crc_update(crc_q, b);
                    if (pay_count < HEAD_DEPTH)
                    begin
                        head_q[pay_count] = b;
                    end
                    pay_count = pay_count + 17'd1;
                    if (pay_count >= {1'b0, len_q})
                    begin
                        phase = PH_CRC_LO;
                    end
                end
                PH_CRC_LO:
                begin
                    crc_lo_q = b;
                    phase = PH_CRC_HI;
                end
                PH_CRC_HI:
                begin
                    r.command = cmd_q;
                    r.seq_num = seq_q;
                    r.pay_len = len_q;
                    if ({b, crc_lo_q} != crc_q)
                    begin
                        r.status = ST_CRC_BAD;
                    end
                    else if (cmd_q == zoom_code && len_q >= ZOOM_MIN_LENGTH)
                    begin
                        r.status = ST_ZOOM;
                        r.zoom = {head_q[1], head_q[0]};
                    end
                    else if ((cmd_q == read_att_code || cmd_q == set_att_code) &&
                             len_q >= ATTITUDE_MIN_LENGTH && !ext_att)
                    begin
                        r.status = ST_ATTITUDE;
                        r.yaw = {head_q[1], head_q[0]};
                        r.pitch = {head_q[3], head_q[2]};
                        r.roll = {head_q[5], head_q[4]};
                    end
                    else
                    begin
                        r.status = ST_IGNORED;
                    end
                    expected_reports.push_back(r);
                    phase = PH_HUNT0;
                end
                default:
                begin
                    phase = PH_HUNT0;
                end
            endcase
        endfunction

        function void compare_field(input string name, input logic [15:0] got,
                                    input logic [15:0] want);
            if (got !== want)
            begin
                report($sformatf("%s got %h expected %h", name, got, want));
            end
        endfunction

        function void check_result(input frame_report_t got);
            frame_report_t want;
            if (expected_reports.size() == 0)
            begin
                report("report transfer with no frame pending");
                return;
            end
            want = expected_reports.pop_front();
            compare_field("status", 16'(got.status), 16'(want.status));
            compare_field("command", 16'(got.command), 16'(want.command));
            compare_field("sequence", got.seq_num, want.seq_num);
            compare_field("payload_length", got.pay_len, want.pay_len);
            compare_field("zoom_tenths", got.zoom, want.zoom);
            compare_field("yaw_raw", got.yaw, want.yaw);
            compare_field("pitch_raw", got.pitch, want.pitch);
            compare_field("roll_raw", got.roll, want.roll);
        endfunction

        function void flag_leftovers();
            if (expected_reports.size() != 0)
            begin
                report($sformatf("%0d reports never arrived", expected_reports.size()));
            end
        endfunction

    endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import cftp_pkg::*;
    import frame_check_pkg::*;

    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_BYTES = 440;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         rx_byte;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic [7:0]         command;
    logic [15:0]        sequence_res;
    logic [15:0]        payload_length;
    logic [15:0]        zoom_tenths;
    logic signed [15:0] yaw_raw;
    logic signed [15:0] pitch_raw;
    logic signed [15:0] roll_raw;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [7:0]         cfg_data;

    frame_scoreboard    sb;
    frame_report_t      seen_report;
    logic [7:0]         payload_q [$];
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 frame_bytes;
    int                 quiet_cycles = 0;
    bit                 paused;

    crc16_framed_telemetry_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .command        (command),
        .sequence_res   (sequence_res),
        .payload_length (payload_length),
        .zoom_tenths    (zoom_tenths),
        .yaw_raw        (yaw_raw),
        .pitch_raw      (pitch_raw),
        .roll_raw       (roll_raw),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            seen_report.status = status_t'(status);
            seen_report.command = command;
            seen_report.seq_num = sequence_res;
            seen_report.pay_len = payload_length;
            seen_report.zoom = zoom_tenths;
            seen_report.yaw = yaw_raw;
            seen_report.pitch = pitch_raw;
            seen_report.roll = roll_raw;
            sb.check_result(seen_report);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (in_stall);
        sb.take_byte(b);
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [15:0] seq,
                              input bit bad_crc, input int keep);
        logic [7:0]  frame_q [$];
        logic [15:0] len;
        logic [15:0] crc;
        int          pos;
        len = 16'(payload_q.size());
        frame_q = {SYNC_FIRST, SYNC_SECOND, 8'($urandom), len[7:0], len[15:8],
                   seq[7:0], seq[15:8], cmd};
        frame_q = {frame_q, payload_q};
        crc = '0;
        foreach (frame_q[i])
        begin
            crc = frame_scoreboard::crc_update(crc, frame_q[i]);
        end
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
        if (bad_crc)
        begin
            pos = $urandom_range(frame_q.size() - 1, 7);
            frame_q[pos] = frame_q[pos] ^ 8'(1 << $urandom_range(7, 0));
        end
        if (keep < 0 || keep > frame_q.size())
        begin
            keep = frame_q.size();
        end
        for (int i = 0; i < keep; i++)
        begin
            send_byte(frame_q[i]);
        end
        frame_bytes += keep;
    endtask

    task automatic random_frame();
        int         len;
        int         keep;
        logic [7:0] cmd;
        case ($urandom_range(9, 0))
            0: len = 0;
            1: len = 1;
            2: len = 2;
            3: len = 5;
            4: len = 6;
            5: len = 7;
            9: len = $urandom_range(40, 13);
            default: len = $urandom_range(12, 0);
        endcase
        case ($urandom_range(7, 0))
            0, 1: cmd = sb.zoom_code;
            2, 3: cmd = sb.read_att_code;
            4, 5: cmd = sb.set_att_code;
            default: cmd = 8'($urandom);
        endcase
        payload_q.delete();
        repeat (len) payload_q.push_back(8'($urandom));
        case ($urandom_range(9, 0))
            0: repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
            1:
            begin
                send_byte(SYNC_FIRST);
                send_byte(8'($urandom));
            end
            2: repeat ($urandom_range(3, 1)) send_byte(SYNC_FIRST);
            default: ;
        endcase
        keep = ($urandom_range(9, 0) == 0) ? $urandom_range(len + 9, 1) : -1;
        send_frame(cmd, 16'($urandom), $urandom_range(6, 0) == 0, keep);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, d);
        @(negedge clk);
    endtask

    task automatic set_config(input logic [7:0] zoom_cmd, input logic [7:0] read_cmd,
                              input logic [7:0] set_cmd, input logic ext);
        write_reg(CFG_ZOOM_COMMAND, zoom_cmd);
        write_reg(CFG_READ_ATT_COMMAND, read_cmd);
        write_reg(CFG_SET_ATT_COMMAND, set_cmd);
        write_reg(CFG_EXTERNAL_ATT, {7'($urandom), ext});
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ZOOM_COMMAND;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        frame_bytes = 0;
        paused = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // With all command codes at zero the zoom test wins over the attitude tests.
        payload_q.delete();
        send_frame(8'h00, 16'h0001, 1'b0, -1);
        payload_q = {8'h34, 8'h12};
        send_frame(8'h00, 16'h0002, 1'b0, -1);
        drain();
        set_config(8'h10, 8'h20, 8'h21, 1'b0);

        send_byte(SYNC_FIRST);
        payload_q = {8'hFF, 8'hFF};
        send_frame(8'h10, 16'h0000, 1'b0, -1);
        payload_q = {8'h00, 8'h80, 8'hFF, 8'h7F, 8'h01, 8'h00};
        send_frame(8'h20, 16'hFFFF, 1'b0, -1);
        payload_q = {8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h80, 8'hAA};
        send_frame(8'h21, 16'h1234, 1'b0, -1);
        payload_q = {8'h33};
        send_frame(8'h10, 16'h8000, 1'b0, -1);
        payload_q = {8'h01, 8'h02, 8'h03, 8'h04, 8'h05};
        send_frame(8'h20, 16'h00FF, 1'b0, -1);
        payload_q = {8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06};
        send_frame(8'h20, 16'h0F0F, 1'b1, -1);
        send_byte(SYNC_FIRST);
        send_byte(8'h12);
        payload_q = {SYNC_FIRST, SYNC_SECOND, 8'h07, 8'h00};
        send_frame(8'h10, 16'h5566, 1'b0, -1);
        payload_q.delete();
        send_frame(8'h20, 16'h7FFF, 1'b0, -1);
        payload_q.delete();
        repeat (256) payload_q.push_back(8'($urandom));
        send_frame(8'h10, 16'hA5A5, 1'b0, -1);

        for (int p = 0; p < 4; p++)
        begin
            drain();
            case (p)
                1: set_config(8'hFF, 8'h00, 8'hFF, 1'b1);
                2: set_config(8'h00, 8'hFF, 8'h80, 1'b0);
                3: set_config(8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
                default: ;
            endcase
            send_idle_pct = (p == 1) ? 71 : (p == 3) ? 27 : 0;
            recv_stall_pct = (p == 2) ? 71 : (p == 3) ? 27 : 0;
            frame_bytes = 0;
            while (frame_bytes < RANDOM_BYTES / 4)
            begin
                random_frame();
                if (p == 1 && !paused && frame_bytes >= RANDOM_BYTES / 8)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
        end

        drain();
        sb.flag_leftovers();
        if (sb.errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
